// ===== rtl/lpfr_pkg.sv =====
// Shared types and constants for the length-prefixed frame receiver.
package lpfr_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] DL_REQ_BYTE0   = 8'hD0;
    localparam logic [7:0] DL_REQ_BYTE1   = 8'h00;
    localparam logic [7:0] TIMEOUT_RESET  = 8'd10;
    localparam logic [7:0] IDLE_MAX       = 8'hFF;
    localparam logic [16:0] DL_HDR_BYTES  = 17'd3;
    localparam logic [16:0] STD_HDR_BYTES = 17'd2;

    localparam int APB_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_SUITE_TYPE = 2'd0,
        REG_DL_DATA    = 2'd1,
        REG_TIMEOUT    = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_NOTHING  = 3'd0,
        ST_WAITING  = 3'd1,
        ST_COMPLETE = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_OTHER  = 2'd0,
        KIND_SUITE  = 2'd1,
        KIND_DL     = 2'd2,
        KIND_DL_REQ = 2'd3
    } kind_t;

    typedef enum logic {
        ITEM_BYTE = 1'b0,
        ITEM_TICK = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] suite_type_byte;
        logic [7:0] download_data_byte;
        logic [7:0] timeout_limit;
    } cfg_t;

    // First field sits in the highest bits.
    typedef struct packed {
        logic [7:0]  phase_byte;
        logic [7:0]  mode_byte;
        logic [16:0] frame_length;
        logic [10:0] byte_count;
        kind_t       frame_kind;
        status_t     status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== rtl/lpfr_front.sv =====
// Input stage: accepts transactions and classifies them as bytes or idle ticks.
module lpfr_front import lpfr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    output logic       q_valid,
    input  logic       q_ready,
    output item_t      q_item
);

    logic  stage_valid_reg, stage_valid_next;
    item_t stage_item_reg, stage_item_next;

    assign s_tready = !stage_valid_reg || q_ready;
    assign q_valid  = stage_valid_reg;
    assign q_item   = stage_item_reg;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        stage_item_next  = stage_item_reg;
        if (s_tready) begin
            stage_valid_next = s_tvalid;
            stage_item_next.kind      = s_tuser ? ITEM_TICK : ITEM_BYTE;
            stage_item_next.data_byte = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
        stage_item_reg <= stage_item_next;
    end

endmodule

// ===== rtl/lpfr_queue.sv =====
// Short queue that decouples the input stage from the frame tracker.
module lpfr_queue import lpfr_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t                    mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] fill_reg, fill_next;
    logic                     push, pop;

    assign in_ready  = fill_reg != ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH);
    assign out_valid = fill_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/lpfr_back.sv =====
// Frame tracker: header capture, length decode, timeout and overflow, result register.
module lpfr_back import lpfr_pkg::*; #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_BYTES);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [3:0][7:0]  hdr_reg, hdr_next;
    logic [16:0]      len_reg, len_next;
    logic             known_reg, known_next;
    logic [7:0]       idle_reg, idle_next;
    logic             out_valid_reg, out_valid_next;
    result_t          result_reg, result_next;

    logic             take;
    logic [7:0]       idle_inc;
    logic [CNT_W-1:0] b_count;
    logic [3:0][7:0]  b_hdr;
    logic             b_known;
    logic [16:0]      b_len;
    logic             b_complete;
    result_t          res;

    // Kind is decoded from the live configuration values and the header as it stands.
    function automatic kind_t decode_kind(input logic nonzero, input logic ge2,
                                          input logic [7:0] b0, input logic [7:0] b1,
                                          input cfg_t c);
        kind_t k;
        k = KIND_OTHER;
        if (!nonzero) begin
            k = KIND_OTHER;
        end else if (b0 == c.suite_type_byte) begin
            k = KIND_SUITE;
        end else if (b0 == c.download_data_byte) begin
            k = KIND_DL;
        end else if (ge2 && b0 == DL_REQ_BYTE0 && b1 == DL_REQ_BYTE1) begin
            k = KIND_DL_REQ;
        end
        return k;
    endfunction

    assign in_ready   = !out_valid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;
    assign idle_inc   = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 8'd1;

    // Header and length as they stand after a received byte.
    always_comb begin
        b_hdr = hdr_reg;
        if (count_reg == '0) begin
            b_hdr = '0;
        end
        for (int i = 0; i < 4; i++) begin
            if (count_reg == CNT_W'(i)) begin
                b_hdr[i] = in_item.data_byte;
            end
        end
        b_count = count_reg + 1'b1;
        b_known = known_reg;
        b_len   = len_reg;
        if (!known_reg) begin
            if (b_hdr[0] == cfg.suite_type_byte) begin
                if (b_count >= CNT_W'(2)) begin
                    b_len   = 17'(b_hdr[1]);
                    b_known = 1'b1;
                end
            end else if (b_hdr[0] == cfg.download_data_byte) begin
                if (b_count >= CNT_W'(3)) begin
                    b_len   = DL_HDR_BYTES + {1'b0, b_hdr[1], b_hdr[2]};
                    b_known = 1'b1;
                end
            end else if (b_count >= CNT_W'(2)) begin
                b_len   = STD_HDR_BYTES + 17'(b_hdr[1]);
                b_known = 1'b1;
            end
        end
        b_complete = b_known && (17'(b_count) >= b_len);
    end

    always_comb begin
        count_next = count_reg;
        hdr_next   = hdr_reg;
        len_next   = len_reg;
        known_next = known_reg;
        idle_next  = idle_reg;
        res        = '0;
        if (take) begin
            unique case (in_item.kind)
                ITEM_TICK: begin
                    if (count_reg != '0) begin
                        idle_next = idle_inc;
                        if (idle_inc > cfg.timeout_limit) begin
                            res.status       = ST_TIMEOUT;
                            res.frame_kind   = decode_kind(1'b1, count_reg >= CNT_W'(2),
                                                           hdr_reg[0], hdr_reg[1], cfg);
                            res.byte_count   = 11'(count_reg);
                            res.frame_length = known_reg ? len_reg : 17'd0;
                            res.mode_byte    = hdr_reg[2];
                            res.phase_byte   = hdr_reg[3];
                            count_next       = '0;
                            len_next         = '0;
                            known_next       = 1'b0;
                            idle_next        = '0;
                        end
                    end
                end
                ITEM_BYTE: begin
                    res.frame_kind   = decode_kind(1'b1, b_count >= CNT_W'(2),
                                                   b_hdr[0], b_hdr[1], cfg);
                    res.byte_count   = 11'(b_count);
                    res.frame_length = b_known ? b_len : 17'd0;
                    res.mode_byte    = b_hdr[2];
                    res.phase_byte   = b_hdr[3];
                    hdr_next         = b_hdr;
                    idle_next        = '0;
                    if (b_complete || b_count == CNT_FULL) begin
                        res.status = b_complete ? ST_COMPLETE : ST_OVERFLOW;
                        count_next = '0;
                        len_next   = '0;
                        known_next = 1'b0;
                    end else begin
                        res.status = ST_WAITING;
                        count_next = b_count;
                        len_next   = b_len;
                        known_next = b_known;
                    end
                end
                default: begin
                    res = '0;
                end
            endcase
        end
        out_valid_next = take ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        result_next    = take ? res : result_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            hdr_reg       <= '0;
            len_reg       <= '0;
            known_reg     <= 1'b0;
            idle_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            hdr_reg       <= hdr_next;
            len_reg       <= len_next;
            known_reg     <= known_next;
            idle_reg      <= idle_next;
            out_valid_reg <= out_valid_next;
        end
        result_reg <= result_next;
    end

endmodule

// ===== rtl/length_prefixed_frame_receiver.sv =====
// Top level of the length-prefixed frame receiver: register port, input stage, queue, tracker.
//
// The receiver takes one transaction per clock on the s_ channel while s_tready is high,
// either a received byte (s_tuser low, byte in s_tdata) or an idle poll tick (s_tuser high),
// and returns exactly one result transaction on the m_ channel for each one, in order.
// Sustained throughput is one item per cycle while m_tready is held high. An accepted item
// passes through the input register, the two-entry queue and the result register, in that
// order, before it appears on the m_ channel. The queue lets the input side keep
// taking items while the result side is stalled, until the queue and input register are full.
// The frame tracker decodes the frame
// length from the first header bytes: a first byte equal to suite_type_byte makes byte 1
// the whole length, a first byte equal to download_data_byte adds three header bytes to a
// big-endian 16-bit length in bytes 1 and 2, and any other first byte gives two plus byte 1.
// Each result reports waiting, complete, timeout discard (more idle ticks in a row than
// timeout_limit while a frame is open) or overflow discard (BUFFER_BYTES bytes without
// completion), with the frame kind, byte count, length and header bytes 2 and 3. The three
// configuration registers sit on the APB port at byte addresses 0, 4 and 8 and should only
// be written while no transaction is in flight.
module length_prefixed_frame_receiver import lpfr_pkg::*; #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,  // [7:0] data_byte
    input  logic                  s_tuser,  // [0] cmd
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] status, [4:3] frame_kind, [15:5] byte_count, [32:16] frame_length,
    // [40:33] mode_byte, [48:41] phase_byte, upper bits zero
    output logic [M_DATA_W-1:0]   m_tdata
);

    cfg_t       cfg_reg, cfg_next;
    reg_index_t reg_sel;
    logic       cfg_write;

    logic       q_in_valid, q_in_ready;
    item_t      q_in_item;
    logic       q_out_valid, q_out_ready;
    item_t      q_out_item;
    result_t    result;

    // Register decode: the word index selects the register, and the byte offset is ignored.
    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (reg_sel)
            REG_SUITE_TYPE: begin
                prdata = 32'(cfg_reg.suite_type_byte);
                if (cfg_write) cfg_next.suite_type_byte = pwdata[7:0];
            end
            REG_DL_DATA: begin
                prdata = 32'(cfg_reg.download_data_byte);
                if (cfg_write) cfg_next.download_data_byte = pwdata[7:0];
            end
            REG_TIMEOUT: begin
                prdata = 32'(cfg_reg.timeout_limit);
                if (cfg_write) cfg_next.timeout_limit = pwdata[7:0];
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.suite_type_byte    <= '0;
            cfg_reg.download_data_byte <= '0;
            cfg_reg.timeout_limit      <= TIMEOUT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lpfr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_in_valid),
        .q_ready  (q_in_ready),
        .q_item   (q_in_item)
    );

    lpfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_item   (q_in_item),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_item  (q_out_item)
    );

    lpfr_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (q_out_valid),
        .in_ready   (q_out_ready),
        .in_item    (q_out_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = M_DATA_W'(result);

endmodule

// ===== rtl/lpfr_checker.sv =====
// Port-level checks for the frame receiver, bound to the top level.
module lpfr_checker import lpfr_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The status of a shown result is always one of the defined codes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= 3'd4)
        else $error("undefined status code");

    // An empty result carries no frame information.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == 3'd0 |-> m_tdata[48:3] == '0)
        else $error("nothing status with nonzero fields");

    // No result is shown in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind length_prefixed_frame_receiver lpfr_checker u_lpfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
